@@ design/adtq_pkg.sv @@
`default_nettype none

package adtq_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 64;
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Widths of the item fields
   localparam int LEN_W  = 16;
   localparam int SEQ_W  = 32;
   localparam int WORD_W = 32;
   localparam int WIN_W  = 16;
   localparam int PROD_W = WORD_W + WIN_W;
   localparam int QCNT_W = 7;

   // Configuration register reset values
   localparam logic [WORD_W-1:0] INITIAL_BUFFER_RESET = 32'd65536;
   localparam logic [WORD_W-1:0] LINE_RATE_RESET      = 32'd1000;

   // Configuration register indexes
   localparam logic REG_INITIAL_BUFFER = 1'b0;
   localparam logic REG_LINE_RATE      = 1'b1;

   // Input commands
   typedef enum logic [1:0] {
      CMD_ARRIVAL = 2'd0,
      CMD_TX_END  = 2'd1,
      CMD_CONTROL = 2'd2
   } command_type;

   // Result actions
   typedef enum logic [2:0] {
      ACT_SENT     = 3'd0,
      ACT_QUEUED   = 3'd1,
      ACT_DROPPED  = 3'd2,
      ACT_IDLE     = 3'd3,
      ACT_ADJUSTED = 3'd4
   } action_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARRIVE,
      ST_DEPART,
      ST_PREP,
      ST_MUL,
      ST_ADJUST
   } state_type;

   // Input item
   typedef struct packed {
      logic [1:0]        command;
      logic [LEN_W-1:0]  packet_length;
      logic [SEQ_W-1:0]  packet_seq;
      logic [WORD_W-1:0] forecast_load;
      logic [WIN_W-1:0]  control_window;
   } req_type;

   // Result item
   typedef struct packed {
      logic [2:0]        action;
      logic [LEN_W-1:0]  item_length;
      logic [SEQ_W-1:0]  item_seq;
      logic [WORD_W-1:0] bytes_used;
      logic [WORD_W-1:0] limit_now;
      logic [QCNT_W-1:0] packets_queued;
      logic              link_busy;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic send;
      logic enqueue;
      logic drop;
      logic pop;
      logic go_idle;
      logic prep;
      logic mul;
      logic adjust;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic link_busy;
      logic fits;
      logic queue_empty;
   } dp_status_type;

endpackage

`default_nettype wire

@@ design/adtq_ctrl.sv @@
`default_nettype none

module adtq_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [1:0]             req_command,
   input  wire adtq_pkg::dp_status_type status,
   output      adtq_pkg::ctrl_cmd_type cmd,
   output      logic                   busy
);

   adtq_pkg::state_type state_ff;
   adtq_pkg::state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= adtq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         adtq_pkg::ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               case (req_command)
                  adtq_pkg::CMD_ARRIVAL: state_in = adtq_pkg::ST_ARRIVE;
                  adtq_pkg::CMD_TX_END:  state_in = adtq_pkg::ST_DEPART;
                  adtq_pkg::CMD_CONTROL: state_in = adtq_pkg::ST_PREP;
                  default:               state_in = adtq_pkg::ST_IDLE;
               endcase
            end
         end
         adtq_pkg::ST_ARRIVE: begin
            // idle link sends at once; busy link queues or drops
            if (!status.link_busy) begin
               cmd.send = 1'b1;
            end else if (status.fits) begin
               cmd.enqueue = 1'b1;
            end else begin
               cmd.drop = 1'b1;
            end
            state_in = adtq_pkg::ST_IDLE;
         end
         adtq_pkg::ST_DEPART: begin
            if (status.queue_empty) begin
               cmd.go_idle = 1'b1;
            end else begin
               cmd.pop = 1'b1;
            end
            state_in = adtq_pkg::ST_IDLE;
         end
         adtq_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = adtq_pkg::ST_MUL;
         end
         adtq_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = adtq_pkg::ST_ADJUST;
         end
         adtq_pkg::ST_ADJUST: begin
            cmd.adjust = 1'b1;
            state_in   = adtq_pkg::ST_IDLE;
         end
         default: begin
            state_in = adtq_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != adtq_pkg::ST_IDLE);

endmodule

`default_nettype wire

@@ design/adtq_datapath.sv @@
`default_nettype none

module adtq_datapath (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire adtq_pkg::req_type       req_data,
   input  wire adtq_pkg::ctrl_cmd_type  cmd,
   output      adtq_pkg::dp_status_type status,
   input  wire logic                    cfg_write,
   input  wire logic                    cfg_index,
   input  wire logic [31:0]             cfg_wdata,
   output      logic [31:0]             cfg_initial_buffer,
   output      logic [31:0]             cfg_line_rate,
   output      logic                    rsp_valid,
   output      adtq_pkg::rsp_type       rsp_data
);

   localparam int PW = adtq_pkg::PTR_W;
   localparam int CW = adtq_pkg::CNT_W;
   localparam int LW = adtq_pkg::LEN_W;
   localparam int SW = adtq_pkg::SEQ_W;
   localparam int WW = adtq_pkg::WORD_W;
   localparam int XW = adtq_pkg::PROD_W;
   localparam int EW = LW + SW;

   // Captured item and configuration
   adtq_pkg::req_type req_ff;
   logic [WW-1:0]     init_ff;
   logic [WW-1:0]     rate_ff;

   // Queue state
   logic          busy_ff,  busy_in;
   logic [WW-1:0] limit_ff, limit_in;
   logic [WW-1:0] used_ff,  used_in;
   logic [PW-1:0] head_ff,  head_in;
   logic [PW-1:0] tail_ff,  tail_in;
   logic [CW-1:0] count_ff, count_in;

   // Descriptor memory and its registered head read
   logic [EW-1:0] store_mem [adtq_pkg::QUEUE_DEPTH];
   logic [EW-1:0] head_rd_ff;

   // Limit adjustment pipeline
   logic          grow_ff;
   logic [WW-1:0] factor_ff;
   logic [XW-1:0] prod_ff;

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   adtq_pkg::rsp_type rsp_ff,       rsp_in;

   logic [WW:0]   bytes_after;
   logic [LW-1:0] head_len;
   logic [SW-1:0] head_seq;
   logic [XW:0]   grow_sum;
   logic [XW:0]   shrink_floor;

   function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
      logic [PW-1:0] nxt;
      if (p == PW'(adtq_pkg::QUEUE_DEPTH - 1)) begin
         nxt = '0;
      end else begin
         nxt = p + PW'(1);
      end
      return nxt;
   endfunction

   assign head_len = head_rd_ff[EW-1:SW];
   assign head_seq = head_rd_ff[SW-1:0];

   // Status for the controller
   assign bytes_after        = {1'b0, used_ff} + {{(WW + 1 - LW){1'b0}}, req_ff.packet_length};
   assign status.link_busy   = busy_ff;
   assign status.fits        = (bytes_after <= {1'b0, limit_ff})
                            && (count_ff < CW'(adtq_pkg::QUEUE_DEPTH));
   assign status.queue_empty = (count_ff == '0);

   // Candidate limits for the adjustment
   assign grow_sum     = {{(XW + 1 - WW){1'b0}}, limit_ff} + {1'b0, prod_ff};
   assign shrink_floor = {{(XW + 1 - WW){1'b0}}, used_ff} + {1'b0, prod_ff};

   // Next state and result
   always_comb begin
      busy_in      = busy_ff;
      limit_in     = limit_ff;
      used_in      = used_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.action      = adtq_pkg::ACT_SENT;
      rsp_in.item_length = req_ff.packet_length;
      rsp_in.item_seq    = req_ff.packet_seq;

      if (cmd.send) begin
         busy_in      = 1'b1;
         rsp_valid_in = 1'b1;
      end
      if (cmd.enqueue) begin
         tail_in       = next_slot(tail_ff);
         count_in      = count_ff + CW'(1);
         used_in       = bytes_after[WW-1:0];
         rsp_in.action = adtq_pkg::ACT_QUEUED;
         rsp_valid_in  = 1'b1;
      end
      if (cmd.drop) begin
         rsp_in.action = adtq_pkg::ACT_DROPPED;
         rsp_valid_in  = 1'b1;
      end
      if (cmd.go_idle) begin
         busy_in            = 1'b0;
         rsp_in.action      = adtq_pkg::ACT_IDLE;
         rsp_in.item_length = '0;
         rsp_in.item_seq    = '0;
         rsp_valid_in       = 1'b1;
      end
      if (cmd.pop) begin
         head_in  = next_slot(head_ff);
         count_in = count_ff - CW'(1);
         if ({{(WW - LW){1'b0}}, head_len} > used_ff) begin
            used_in = '0;
         end else begin
            used_in = used_ff - {{(WW - LW){1'b0}}, head_len};
         end
         busy_in            = 1'b1;
         rsp_in.item_length = head_len;
         rsp_in.item_seq    = head_seq;
         rsp_valid_in       = 1'b1;
      end
      if (cmd.adjust) begin
         if (grow_ff) begin
            // grow, saturating at the top of the range
            if (grow_sum[XW:WW] != '0) begin
               limit_in = '1;
            end else begin
               limit_in = grow_sum[WW-1:0];
            end
         end else if ({{(XW + 1 - WW){1'b0}}, limit_ff} > shrink_floor) begin
            limit_in = limit_ff - prod_ff[WW-1:0];
         end else begin
            limit_in = used_ff;
         end
         rsp_in.action      = adtq_pkg::ACT_ADJUSTED;
         rsp_in.item_length = '0;
         rsp_in.item_seq    = '0;
         rsp_valid_in       = 1'b1;
      end
      // writing the initial limit reloads the live limit
      if (cfg_write && (cfg_index == adtq_pkg::REG_INITIAL_BUFFER)) begin
         limit_in = cfg_wdata;
      end

      rsp_in.bytes_used     = used_in;
      rsp_in.limit_now      = limit_in;
      rsp_in.packets_queued = adtq_pkg::QCNT_W'(count_in);
      rsp_in.link_busy      = busy_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         limit_ff     <= adtq_pkg::INITIAL_BUFFER_RESET;
         used_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         init_ff      <= adtq_pkg::INITIAL_BUFFER_RESET;
         rate_ff      <= adtq_pkg::LINE_RATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         limit_ff     <= limit_in;
         used_ff      <= used_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_write) begin
            if (cfg_index == adtq_pkg::REG_INITIAL_BUFFER) begin
               init_ff <= cfg_wdata;
            end else begin
               rate_ff <= cfg_wdata;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.prep) begin
         grow_ff <= (req_ff.forecast_load > rate_ff);
         if (req_ff.forecast_load > rate_ff) begin
            factor_ff <= req_ff.forecast_load - rate_ff;
         end else begin
            factor_ff <= rate_ff;
         end
      end
      if (cmd.mul) begin
         prod_ff <= XW'(factor_ff) * XW'(req_ff.control_window);
      end
      rsp_ff <= rsp_in;
   end

   // Descriptor memory: write at tail, read head every cycle
   always_ff @(posedge clock) begin
      if (cmd.enqueue) begin
         store_mem[tail_ff] <= {req_ff.packet_length, req_ff.packet_seq};
      end
      head_rd_ff <= store_mem[head_ff];
   end

   assign cfg_initial_buffer = init_ff;
   assign cfg_line_rate      = rate_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_ff;

endmodule

`default_nettype wire

@@ design/adaptive_drop_tail_byte_queue_unit.sv @@
//  Channel   Ports                                  Handshake
//  request   start, busy, req_data                  taken when start && !busy
//  result    rsp_valid, rsp_data                    one-cycle strobe, no stall
//  config    psel penable pwrite paddr pwdata ...   APB write, pready tied high
//
//  An arrival or a transmission end holds busy while it is handled, a buffer
//  control through operand select, 48-bit multiply and limit update; an unknown
//  command never raises busy. The result strobes in the first cycle with busy
//  low again. Reset is synchronous; the descriptor memory is not cleared.
//  The receiver cannot stall results.
`default_nettype none

module adaptive_drop_tail_byte_queue_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output      logic              busy,
   input  wire adtq_pkg::req_type req_data,
   output      logic              rsp_valid,
   output      adtq_pkg::rsp_type rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output      logic [31:0]       prdata,
   output      logic              pready
);

   adtq_pkg::ctrl_cmd_type  ctrl_cmd;
   adtq_pkg::dp_status_type dp_status;
   logic                    cfg_write;
   logic [31:0]             cfg_initial_buffer;
   logic [31:0]             cfg_line_rate;

   // Decode register writes and reads
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == adtq_pkg::REG_LINE_RATE) ? cfg_line_rate
                                                            : cfg_initial_buffer;

   adtq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_data.command),
      .status      (dp_status),
      .cmd         (ctrl_cmd),
      .busy        (busy)
   );

   adtq_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_data           (req_data),
      .cmd                (ctrl_cmd),
      .status             (dp_status),
      .cfg_write          (cfg_write),
      .cfg_index          (paddr[2]),
      .cfg_wdata          (pwdata),
      .cfg_initial_buffer (cfg_initial_buffer),
      .cfg_line_rate      (cfg_line_rate),
      .rsp_valid          (rsp_valid),
      .rsp_data           (rsp_data)
   );

endmodule

`default_nettype wire
